// ===== rtl/core/stq_pkg.sv =====
// shared types and codes of the start-time ordered task queue
package stq_pkg;

  localparam int CAPACITY  = 16;
  localparam int TIME_BITS = 32;
  localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W     = $clog2(CAPACITY + 1);

  localparam logic [1:0] OP_INSERT   = 2'd0;
  localparam logic [1:0] OP_DISPATCH = 2'd1;
  localparam logic [1:0] OP_CLEAR    = 2'd2;

  localparam logic [2:0] ST_EMIT     = 3'd0;
  localparam logic [2:0] ST_INSERTED = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_EMPTY    = 3'd3;
  localparam logic [2:0] ST_CLEARED  = 3'd4;

  typedef struct packed {
    logic [TIME_BITS-1:0] start;
    logic [7:0]           task_id;
    logic [31:0]          param;
  } entry_t;

endpackage

// ===== rtl/core/stq_ifs.sv =====
// handshake interfaces of the queue's request and result channels
interface stq_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic [31:0]        start_time;
  logic [7:0]         task_id;
  logic signed [31:0] task_param;

  modport source (output valid, output op, output start_time, output task_id,
                  output task_param, input ready);
  modport sink   (input valid, input op, input start_time, input task_id,
                  input task_param, output ready);
endinterface

interface stq_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [7:0]         out_task_id;
  logic signed [31:0] out_param;
  logic [31:0]        out_start;
  logic               last;

  modport source (output valid, output status, output out_task_id, output out_param,
                  output out_start, output last, input ready);
  modport sink   (input valid, input status, input out_task_id, input out_param,
                  input out_start, input last, output ready);
endinterface

// ===== rtl/core/start_time_ordered_task_queue.sv =====
// sorted task queue: entry memory, one shared start-time comparator and a small sequencer
// clear, full and empty-dispatch words and an insert into an empty queue come out in the
//   cycle after accept; other inserts move each entry with a later start time up one slot
// dispatch: one entry per cycle after the first registered read, while out is ready
// one request at a time; the single comparator and the one-port-each memory set the pace
// reset: synchronous, active low; empties the queue and the output, entries are not cleared
module start_time_ordered_task_queue (
  input  logic       clk,
  input  logic       rst_n,
  stq_in_if.sink     in_ch,
  stq_out_if.source  out_ch
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_INS  = 2'd1;
  localparam logic [1:0] S_PUT  = 2'd2;
  localparam logic [1:0] S_DSP  = 2'd3;

  logic [1:0]                 state_r, state_nxt;
  logic [stq_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [stq_pkg::IDX_W-1:0]  idx_r, idx_nxt;
  stq_pkg::entry_t            new_r, new_nxt;

  stq_pkg::entry_t            entry_mem_r [stq_pkg::CAPACITY];
  stq_pkg::entry_t            rd_data_r;
  logic                       wr_en, rd_en;
  logic [stq_pkg::IDX_W-1:0]  wr_addr, rd_addr;
  stq_pkg::entry_t            wr_data;

  logic                       ovalid_r, ovalid_nxt;
  logic [2:0]                 ostatus_r, ostatus_nxt;
  logic [7:0]                 otask_r, otask_nxt;
  logic [31:0]                oparam_r, oparam_nxt;
  logic [31:0]                ostart_r, ostart_nxt;
  logic                       olast_r, olast_nxt;

  logic                       out_free, accept, later;
  logic                       res_load, res_last;
  logic [2:0]                 res_status;
  stq_pkg::entry_t            res_entry, in_entry;

  assign out_free = !ovalid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && out_free;
  assign accept = in_ch.valid && in_ch.ready;

  assign in_entry.start   = stq_pkg::TIME_BITS'(in_ch.start_time);
  assign in_entry.task_id = in_ch.task_id;
  assign in_entry.param   = in_ch.task_param;

  // the shared comparator: stored entry against the key being inserted
  assign later = rd_data_r.start > new_r.start;

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    new_nxt    = new_r;
    wr_en      = 1'b0;
    wr_addr    = idx_r;
    wr_data    = new_r;
    rd_en      = 1'b0;
    rd_addr    = '0;
    res_load   = 1'b0;
    res_status = stq_pkg::ST_EMIT;
    res_entry  = '0;
    res_last   = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_ch.op)
            stq_pkg::OP_INSERT: begin
              if (count_r == stq_pkg::CNT_W'(stq_pkg::CAPACITY)) begin
                res_load   = 1'b1;
                res_status = stq_pkg::ST_FULL;
              end else if (count_r == '0) begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                wr_data    = in_entry;
                count_nxt  = count_r + stq_pkg::CNT_W'(1);
                res_load   = 1'b1;
                res_status = stq_pkg::ST_INSERTED;
              end else begin
                // walk down from the top, moving later entries up one slot
                new_nxt   = in_entry;
                idx_nxt   = stq_pkg::IDX_W'(count_r);
                rd_en     = 1'b1;
                rd_addr   = stq_pkg::IDX_W'(count_r - stq_pkg::CNT_W'(1));
                state_nxt = S_INS;
              end
            end
            stq_pkg::OP_DISPATCH: begin
              if (count_r == '0) begin
                res_load   = 1'b1;
                res_status = stq_pkg::ST_EMPTY;
              end else begin
                idx_nxt   = '0;
                rd_en     = 1'b1;
                rd_addr   = '0;
                state_nxt = S_DSP;
              end
            end
            stq_pkg::OP_CLEAR: begin
              count_nxt  = '0;
              res_load   = 1'b1;
              res_status = stq_pkg::ST_CLEARED;
            end
            default: ;
          endcase
        end
      end
      S_INS: begin
        // rd_data_r holds the entry just below idx_r
        wr_en = 1'b1;
        if (later) begin
          wr_data = rd_data_r;
          idx_nxt = idx_r - stq_pkg::IDX_W'(1);
          if (idx_r == stq_pkg::IDX_W'(1)) begin
            state_nxt = S_PUT;
          end else begin
            rd_en   = 1'b1;
            rd_addr = idx_r - stq_pkg::IDX_W'(1) - stq_pkg::IDX_W'(1);
          end
        end else begin
          count_nxt  = count_r + stq_pkg::CNT_W'(1);
          res_load   = 1'b1;
          res_status = stq_pkg::ST_INSERTED;
          state_nxt  = S_IDLE;
        end
      end
      S_PUT: begin
        wr_en      = 1'b1;
        count_nxt  = count_r + stq_pkg::CNT_W'(1);
        res_load   = 1'b1;
        res_status = stq_pkg::ST_INSERTED;
        state_nxt  = S_IDLE;
      end
      S_DSP: begin
        if (out_free) begin
          res_load   = 1'b1;
          res_status = stq_pkg::ST_EMIT;
          res_entry  = rd_data_r;
          res_last   = (stq_pkg::CNT_W'(idx_r) + stq_pkg::CNT_W'(1)) == count_r;
          if (res_last) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r + stq_pkg::IDX_W'(1);
            rd_en   = 1'b1;
            rd_addr = idx_r + stq_pkg::IDX_W'(1);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ovalid_nxt  = ovalid_r;
    ostatus_nxt = ostatus_r;
    otask_nxt   = otask_r;
    oparam_nxt  = oparam_r;
    ostart_nxt  = ostart_r;
    olast_nxt   = olast_r;
    if (res_load) begin
      ovalid_nxt  = 1'b1;
      ostatus_nxt = res_status;
      otask_nxt   = res_entry.task_id;
      oparam_nxt  = res_entry.param;
      ostart_nxt  = 32'(res_entry.start);
      olast_nxt   = res_last;
    end else if (out_ch.ready) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      idx_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      idx_r    <= idx_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    new_r     <= new_nxt;
    ostatus_r <= ostatus_nxt;
    otask_r   <= otask_nxt;
    oparam_r  <= oparam_nxt;
    ostart_r  <= ostart_nxt;
    olast_r   <= olast_nxt;
  end

  // entry memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= entry_mem_r[rd_addr];
    end
  end

  assign out_ch.valid       = ovalid_r;
  assign out_ch.status      = ostatus_r;
  assign out_ch.out_task_id = otask_r;
  assign out_ch.out_param   = oparam_r;
  assign out_ch.out_start   = ostart_r;
  assign out_ch.last        = olast_r;

endmodule

// ===== rtl/core/stq_checker.sv =====
// port-level checks of the task queue, bound to the top level
module stq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [7:0]  out_task_id,
  input logic [31:0] out_param,
  input logic [31:0] out_start,
  input logic        last
);

  // a stalled word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(status) && $stable(out_task_id)
      && $stable(out_param) && $stable(out_start) && $stable(last))
    else $error("stalled result word changed");

  // status words carry no entry and close their request
  a_status_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != stq_pkg::ST_EMIT |-> last && out_task_id == 8'd0
      && out_param == 32'd0 && out_start == 32'd0)
    else $error("status word with entry payload or without last");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word after reset");

endmodule

bind start_time_ordered_task_queue stq_checker u_stq_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .status      (out_ch.status),
  .out_task_id (out_ch.out_task_id),
  .out_param   (out_ch.out_param),
  .out_start   (out_ch.out_start),
  .last        (out_ch.last)
);

// ===== test/testbench.sv =====
// self-checking testbench for the start-time ordered task queue: table then random traffic
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 280;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PRINT_CAP = 50;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  task_id;
    logic [31:0] param;
    logic [31:0] start;
    logic        last;
  } word_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] start;
    logic [7:0]  task_id;
    logic [31:0] param;
    bit          typed;
    logic [2:0]  status;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  stq_in_if  in_ch ();
  stq_out_if out_ch ();

  start_time_ordered_task_queue uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // directed part: status typed in where it is obvious, the rest comes from the predictor
  stim_row_t plan [0:22] = '{
    '{stq_pkg::OP_DISPATCH, 32'd0,         8'd0,  32'd0,         1'b1, stq_pkg::ST_EMPTY},
    '{OP_UNUSED,            32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 1'b0, stq_pkg::ST_EMIT},
    '{stq_pkg::OP_INSERT,   32'd100,       8'd1,  32'h8000_0000, 1'b1, stq_pkg::ST_INSERTED},
    '{stq_pkg::OP_INSERT,   32'hFFFF_FFFF, 8'hFF, 32'h7FFF_FFFF, 1'b1, stq_pkg::ST_INSERTED},
    '{stq_pkg::OP_INSERT,   32'd0,         8'd0,  32'd0,         1'b1, stq_pkg::ST_INSERTED},
    '{stq_pkg::OP_INSERT,   32'd100,       8'd2,  32'hFFFF_FFFF, 1'b1, stq_pkg::ST_INSERTED},
    '{stq_pkg::OP_INSERT,   32'd0,         8'd3,  32'd1,         1'b1, stq_pkg::ST_INSERTED},
    '{stq_pkg::OP_DISPATCH, 32'hDEAD_BEEF, 8'h5A, 32'h1234_5678, 1'b0, stq_pkg::ST_EMIT},
    '{stq_pkg::OP_INSERT,   32'hFFFF_FFFE, 8'd4,  32'h5555_5555, 1'b1, stq_pkg::ST_INSERTED},
    '{stq_pkg::OP_INSERT,   32'd50,        8'd5,  32'hAAAA_AAAA, 1'b1, stq_pkg::ST_INSERTED},
    '{stq_pkg::OP_INSERT,   32'd150,       8'd6,  32'd6,         1'b1, stq_pkg::ST_INSERTED},
    '{stq_pkg::OP_INSERT,   32'd100,       8'd7,  32'd7,         1'b1, stq_pkg::ST_INSERTED},
    '{stq_pkg::OP_INSERT,   32'd1,         8'd8,  32'hFFFF_FFF8, 1'b1, stq_pkg::ST_INSERTED},
    '{stq_pkg::OP_INSERT,   32'd99,        8'd9,  32'd9,         1'b1, stq_pkg::ST_INSERTED},
    '{stq_pkg::OP_INSERT,   32'd101,       8'd10, 32'd10,        1'b1, stq_pkg::ST_INSERTED},
    '{stq_pkg::OP_INSERT,   32'h8000_0000, 8'd11, 32'h0F0F_0F0F, 1'b1, stq_pkg::ST_INSERTED},
    '{stq_pkg::OP_INSERT,   32'h7FFF_FFFF, 8'd12, 32'hF0F0_F0F0, 1'b1, stq_pkg::ST_INSERTED},
    '{stq_pkg::OP_INSERT,   32'd0,         8'd13, 32'd13,        1'b1, stq_pkg::ST_INSERTED},
    '{stq_pkg::OP_INSERT,   32'd100,       8'd14, 32'd14,        1'b1, stq_pkg::ST_INSERTED},
    '{stq_pkg::OP_INSERT,   32'd42,        8'hEE, 32'd42,        1'b1, stq_pkg::ST_FULL},
    '{stq_pkg::OP_DISPATCH, 32'd7,         8'd7,  32'd7,         1'b0, stq_pkg::ST_EMIT},
    '{stq_pkg::OP_CLEAR,    32'hCAFE_F00D, 8'hA5, 32'h8765_4321, 1'b1, stq_pkg::ST_CLEARED},
    '{stq_pkg::OP_DISPATCH, 32'd0,         8'd0,  32'd0,         1'b1, stq_pkg::ST_EMPTY}
  };

  stq_pkg::entry_t held [stq_pkg::CAPACITY];
  int     held_count;
  word_t  step_words [$];
  word_t  pending_words [$];
  word_t  head;
  int     mismatches = 0;
  int     cycles = 0;
  int     send_mode;
  int     recv_mode;

  function automatic word_t status_word(input logic [2:0] status);
    return '{status, 8'd0, 32'd0, 32'd0, 1'b1};
  endfunction

  function automatic int idle_cycles(input int mode);
    case (mode)
      0: return 0;
      1: return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 17)) : 0;
      default: return $urandom_range(0, 17);
    endcase
  endfunction

  // keeps its own sorted copy of the entries and lists the words one request causes
  task predict_queue_op(input logic [1:0] op, input logic [31:0] st, input logic [7:0] tid,
                        input logic [31:0] prm);
    int pos;
    step_words.delete();
    case (op)
      stq_pkg::OP_INSERT: begin
        if (held_count >= stq_pkg::CAPACITY) begin
          step_words.push_back(status_word(stq_pkg::ST_FULL));
        end else begin
          // new entry goes after every entry with an equal or lower start time
          pos = held_count;
          for (int i = held_count - 1; i >= 0; i--)
            if (held[i].start > stq_pkg::TIME_BITS'(st)) pos = i;
          for (int i = held_count; i > pos; i--)
            held[i] = held[i-1];
          held[pos] = '{start: stq_pkg::TIME_BITS'(st), task_id: tid, param: prm};
          held_count++;
          step_words.push_back(status_word(stq_pkg::ST_INSERTED));
        end
      end
      stq_pkg::OP_DISPATCH: begin
        if (held_count == 0) begin
          step_words.push_back(status_word(stq_pkg::ST_EMPTY));
        end else begin
          for (int i = 0; i < held_count; i++)
            step_words.push_back('{stq_pkg::ST_EMIT, held[i].task_id, held[i].param,
                                   32'(held[i].start), i == held_count - 1});
        end
      end
      stq_pkg::OP_CLEAR: begin
        held_count = 0;
        step_words.push_back(status_word(stq_pkg::ST_CLEARED));
      end
      default: ;
    endcase
  endtask

  task report_mismatch(input string what);
    if (mismatches < PRINT_CAP)
      $display("mismatch at cycle %0d: %s", cycles, what);
    mismatches++;
  endtask

  task automatic send_word(input logic [1:0] op, input logic [31:0] st, input logic [7:0] tid,
                           input logic [31:0] prm, input bit typed, input logic [2:0] status);
    int gap;
    gap = idle_cycles(send_mode);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.op         <= op;
    in_ch.start_time <= st;
    in_ch.task_id    <= tid;
    in_ch.task_param <= prm;
    do @(posedge clk); while (!in_ch.ready);
    predict_queue_op(op, st, tid, prm);
    if (typed) begin
      pending_words.push_back(status_word(status));
    end else begin
      foreach (step_words[k]) pending_words.push_back(step_words[k]);
    end
  endtask

  function automatic logic [31:0] pick_start();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom_range(0, 7);
      4: return 32'd0;
      5: return 32'hFFFF_FFFF;
      6, 7: return $urandom;
      default: return $urandom_range(0, 1000);
    endcase
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still pending", cycles,
               pending_words.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word, status %0d", out_ch.status));
      end else begin
        head = pending_words.pop_front();
        if (out_ch.status !== head.status)
          report_mismatch($sformatf("status %0d, want %0d", out_ch.status, head.status));
        if (out_ch.out_task_id !== head.task_id)
          report_mismatch($sformatf("task id %0d, want %0d", out_ch.out_task_id,
                                    head.task_id));
        if (out_ch.out_param !== head.param)
          report_mismatch($sformatf("param %h, want %h", out_ch.out_param, head.param));
        if (out_ch.out_start !== head.start)
          report_mismatch($sformatf("start %h, want %h", out_ch.out_start, head.start));
        if (out_ch.last !== head.last)
          report_mismatch($sformatf("last %b, want %b", out_ch.last, head.last));
      end
    end
  end

  // result side: random stalls before each word, mode changes now and then
  initial begin
    int gap;
    int words;
    words = 0;
    recv_mode = 0;
    out_ch.ready = 1'b0;
    forever begin
      if (words % 30 == 0) recv_mode = $urandom_range(0, 2);
      gap = idle_cycles(recv_mode);
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      words++;
    end
  end

  initial begin
    int sent;
    int pick;
    logic [1:0] op;
    held_count = 0;
    send_mode = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.op = stq_pkg::OP_INSERT;
    in_ch.start_time = 32'd0;
    in_ch.task_id = 8'd0;
    in_ch.task_param = 32'sd0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < $size(plan); r++) begin
      if (r % 8 == 0) send_mode = $urandom_range(0, 2);
      send_word(plan[r].op, plan[r].start, plan[r].task_id, plan[r].param, plan[r].typed,
                plan[r].status);
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent % 25 == 0) send_mode = $urandom_range(0, 2);
      // hold off until the queue has answered everything sent so far
      if (sent == RANDOM_ITEMS / 2 || $urandom_range(0, 39) == 0) begin
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_words.size() != 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 3) op = OP_UNUSED;
      else if (pick < 7) op = stq_pkg::OP_CLEAR;
      else if (pick < 27) op = stq_pkg::OP_DISPATCH;
      else op = stq_pkg::OP_INSERT;
      send_word(op, pick_start(), 8'($urandom), $urandom, 1'b0, stq_pkg::ST_EMIT);
      if (op != OP_UNUSED) sent++;
    end

    in_ch.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
